### hdl/gcv_pkg.sv
`default_nettype none
package gcv_pkg;

    localparam int MAX_SCANOUTS = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] LIM31        = 32'h7FFF_FFFF;
    localparam logic [31:0] HDR_BYTES    = 32'd24;
    localparam logic [31:0] TRAIL_BASE   = 32'd32;
    localparam logic [31:0] NAME_MAX     = 32'd64;
    localparam logic [15:0] MAX_BYTES_RST = 16'd4096;

    // w*h*4 <= 2^31-1  <=>  w*h < 2^29
    localparam int AREA_W     = 62;
    localparam int AREA_LIMIT = 29;

    localparam logic [31:0] TYPE_GET_DISPLAY_INFO = 32'h0000_0100;
    localparam logic [31:0] TYPE_RES_CREATE_2D    = 32'h0000_0101;
    localparam logic [31:0] TYPE_RES_UNREF        = 32'h0000_0102;
    localparam logic [31:0] TYPE_SET_SCANOUT      = 32'h0000_0103;
    localparam logic [31:0] TYPE_RES_FLUSH        = 32'h0000_0104;
    localparam logic [31:0] TYPE_XFER_TO_HOST_2D  = 32'h0000_0105;
    localparam logic [31:0] TYPE_ATTACH_BACKING   = 32'h0000_0106;
    localparam logic [31:0] TYPE_DETACH_BACKING   = 32'h0000_0107;
    localparam logic [31:0] TYPE_GET_CAPSET_INFO  = 32'h0000_0108;
    localparam logic [31:0] TYPE_GET_CAPSET       = 32'h0000_0109;
    localparam logic [31:0] TYPE_CTX_CREATE       = 32'h0000_0200;
    localparam logic [31:0] TYPE_CTX_DESTROY      = 32'h0000_0201;
    localparam logic [31:0] TYPE_CTX_ATTACH_RES   = 32'h0000_0202;
    localparam logic [31:0] TYPE_CTX_DETACH_RES   = 32'h0000_0203;
    localparam logic [31:0] TYPE_RES_CREATE_3D    = 32'h0000_0204;
    localparam logic [31:0] TYPE_XFER_TO_HOST_3D  = 32'h0000_0205;
    localparam logic [31:0] TYPE_XFER_FROM_HOST_3D = 32'h0000_0206;
    localparam logic [31:0] TYPE_SUBMIT_3D        = 32'h0000_0207;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNSPEC   = 3'd1,
        ST_OOM      = 3'd2,
        ST_SCANOUT  = 3'd3,
        ST_RESOURCE = 3'd4,
        ST_CONTEXT  = 3'd5,
        ST_PARAM    = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        CFG_STRICT    = 1'b0,
        CFG_MAX_BYTES = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        CK_DISPLAY,
        CK_CREATE_2D,
        CK_UNREF,
        CK_SET_SCANOUT,
        CK_FLUSH,
        CK_XFER_2D,
        CK_ATTACH,
        CK_CAPSET,
        CK_CTX_CREATE,
        CK_CTX_DESTROY,
        CK_CTX_RES,
        CK_CREATE_3D,
        CK_XFER_3D,
        CK_SUBMIT,
        CK_UNKNOWN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic        len_short;
        logic        len_long;
        logic        len_gt32;
        logic        len_match;
        logic        ctx_zero;
        logic        rid_zero;
        logic        strict;
        logic        sid_bad;
        logic        xy_bad;
        logic        zd_bad;
        logic        wh_bad;
        logic        fmt_ok;
        logic        aux_big;
        logic [30:0] width;
        logic [30:0] height;
    } cmd_info_t;

endpackage
`default_nettype wire

### hdl/gcv_if.sv
`default_nettype none
interface gcv_cmd_if;
    logic        valid;
    logic        ready;
    logic [31:0] command_type;
    logic [31:0] byte_count;
    logic [31:0] context_id;
    logic [31:0] res_id;
    logic [31:0] display_index;
    logic [31:0] rect_x;
    logic [31:0] rect_y;
    logic [31:0] rect_z;
    logic [31:0] rect_width;
    logic [31:0] rect_height;
    logic [31:0] rect_depth;
    logic [31:0] aux_value;

    modport source (
        output valid, command_type, byte_count, context_id, res_id, display_index,
               rect_x, rect_y, rect_z, rect_width, rect_height, rect_depth, aux_value,
        input  ready
    );
    modport sink (
        input  valid, command_type, byte_count, context_id, res_id, display_index,
               rect_x, rect_y, rect_z, rect_width, rect_height, rect_depth, aux_value,
        output ready
    );
endinterface

interface gcv_status_if;
    import gcv_pkg::*;
    logic    valid;
    logic    ready;
    status_t status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

interface gcv_cfg_if;
    import gcv_pkg::*;
    logic        valid;
    logic        ready;
    cfg_index_t  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/gcv_front.sv
`default_nettype none
module gcv_front (
    gcv_cmd_if.sink           cmd,
    input  wire logic         strict,
    input  wire logic [15:0]  max_bytes,
    input  wire logic         queue_full,
    output logic              push,
    output gcv_pkg::cmd_info_t info
);
    import gcv_pkg::*;

    cmd_kind_t   kind;
    logic [6:0]  exact_len;
    logic        exact_eq;
    logic        attach_eq;
    logic        submit_eq;
    logic        fmt_ok;

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    always_comb
    begin
        case (cmd.command_type)
            TYPE_GET_DISPLAY_INFO:  kind = CK_DISPLAY;
            TYPE_RES_CREATE_2D:     kind = CK_CREATE_2D;
            TYPE_RES_UNREF:         kind = CK_UNREF;
            TYPE_DETACH_BACKING:    kind = CK_UNREF;
            TYPE_SET_SCANOUT:       kind = CK_SET_SCANOUT;
            TYPE_RES_FLUSH:         kind = CK_FLUSH;
            TYPE_XFER_TO_HOST_2D:   kind = CK_XFER_2D;
            TYPE_ATTACH_BACKING:    kind = CK_ATTACH;
            TYPE_GET_CAPSET_INFO:   kind = CK_CAPSET;
            TYPE_GET_CAPSET:        kind = CK_CAPSET;
            TYPE_CTX_CREATE:        kind = CK_CTX_CREATE;
            TYPE_CTX_DESTROY:       kind = CK_CTX_DESTROY;
            TYPE_CTX_ATTACH_RES:    kind = CK_CTX_RES;
            TYPE_CTX_DETACH_RES:    kind = CK_CTX_RES;
            TYPE_RES_CREATE_3D:     kind = CK_CREATE_3D;
            TYPE_XFER_TO_HOST_3D:   kind = CK_XFER_3D;
            TYPE_XFER_FROM_HOST_3D: kind = CK_XFER_3D;
            TYPE_SUBMIT_3D:         kind = CK_SUBMIT;
            default:                kind = CK_UNKNOWN;
        endcase
    end

    // struct sizes per the published layout
    always_comb
    begin
        case (kind)
            CK_DISPLAY, CK_CTX_DESTROY:        exact_len = 7'd24;
            CK_UNREF, CK_CAPSET, CK_CTX_RES:   exact_len = 7'd32;
            CK_CREATE_2D:                      exact_len = 7'd40;
            CK_SET_SCANOUT, CK_FLUSH:          exact_len = 7'd48;
            CK_XFER_2D:                        exact_len = 7'd56;
            CK_CREATE_3D, CK_XFER_3D:          exact_len = 7'd72;
            CK_CTX_CREATE:                     exact_len = 7'd96;
            default:                           exact_len = 7'd0;
        endcase
    end

    always_comb
    begin
        case (cmd.aux_value)
            32'd1, 32'd2, 32'd3, 32'd4, 32'd67, 32'd68, 32'd121, 32'd134: fmt_ok = 1'b1;
            default: fmt_ok = 1'b0;
        endcase
    end

    assign exact_eq  = cmd.byte_count == {25'd0, exact_len};
    assign attach_eq = ({1'b0, cmd.aux_value, 4'b0000} + {5'd0, TRAIL_BASE})
                       == {5'd0, cmd.byte_count};
    assign submit_eq = ({1'b0, cmd.aux_value} + {1'b0, TRAIL_BASE})
                       == {1'b0, cmd.byte_count};

    always_comb
    begin
        info.kind      = kind;
        info.len_short = cmd.byte_count < HDR_BYTES;
        info.len_long  = cmd.byte_count > {16'd0, max_bytes};
        info.len_gt32  = cmd.byte_count > TRAIL_BASE;
        info.len_match = (kind == CK_ATTACH) ? attach_eq :
                         (kind == CK_SUBMIT) ? submit_eq : exact_eq;
        info.ctx_zero  = cmd.context_id == 32'd0;
        info.rid_zero  = cmd.res_id == 32'd0;
        info.strict    = strict;
        info.sid_bad   = cmd.display_index >= 32'(MAX_SCANOUTS);
        info.xy_bad    = (cmd.rect_x > LIM31) || (cmd.rect_y > LIM31);
        info.zd_bad    = (cmd.rect_z > LIM31) || (cmd.rect_depth > LIM31);
        info.wh_bad    = (cmd.rect_width == 32'd0) || (cmd.rect_width > LIM31) ||
                         (cmd.rect_height == 32'd0) || (cmd.rect_height > LIM31);
        info.fmt_ok    = fmt_ok;
        info.aux_big   = cmd.aux_value > NAME_MAX;
        info.width     = cmd.rect_width[30:0];
        info.height    = cmd.rect_height[30:0];
    end

endmodule
`default_nettype wire

### hdl/gcv_queue.sv
`default_nettype none
module gcv_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire gcv_pkg::cmd_info_t push_info,
    output logic                    full,
    input  wire logic               pop,
    output gcv_pkg::cmd_info_t      pop_info,
    output logic                    empty
);
    import gcv_pkg::*;

    cmd_info_t           store_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   wr_ptr_reg;
    logic [QUEUE_AW:0]   wr_ptr_next;
    logic [QUEUE_AW:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]   rd_ptr_next;

    assign empty = wr_ptr_reg == rd_ptr_reg;
    assign full  = (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]) &&
                   (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0]);

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign pop_info    = store_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_info;
        end
    end

endmodule
`default_nettype wire

### hdl/gcv_back.sv
`default_nettype none
module gcv_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               queue_empty,
    input  wire gcv_pkg::cmd_info_t head_info,
    output logic                    pop,
    gcv_status_if.source            rsp
);
    import gcv_pkg::*;

    logic              a_valid_reg;
    logic              a_valid_next;
    cmd_info_t         a_info_reg;
    logic [AREA_W-1:0] a_area_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           out_status_reg;
    status_t           status_next;
    logic              out_adv;
    logic              a_adv;
    logic              area_ok;
    logic              rect_fail;
    logic              size_fail;

    assign out_adv = !out_valid_reg || rsp.ready;
    assign a_adv   = !a_valid_reg || out_adv;
    assign pop     = a_adv && !queue_empty;

    assign a_valid_next   = pop ? 1'b1 : (out_adv ? 1'b0 : a_valid_reg);
    assign out_valid_next = out_adv ? a_valid_reg : out_valid_reg;

    assign area_ok   = a_area_reg[AREA_W-1:AREA_LIMIT] == '0;
    assign size_fail = a_info_reg.wh_bad || !area_ok;
    assign rect_fail = a_info_reg.xy_bad || size_fail;

    always_comb
    begin
        status_next = ST_OK;
        if (a_info_reg.len_short)
        begin
            status_next = ST_PARAM;
        end
        else if (a_info_reg.len_long)
        begin
            status_next = ST_OOM;
        end
        else
        begin
            case (a_info_reg.kind)
                CK_DISPLAY, CK_CAPSET:
                    status_next = a_info_reg.len_match ? ST_OK : ST_PARAM;
                CK_CREATE_2D:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.rid_zero) status_next = ST_RESOURCE;
                    else if (size_fail || !a_info_reg.fmt_ok) status_next = ST_PARAM;
                CK_UNREF:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.rid_zero) status_next = ST_RESOURCE;
                CK_SET_SCANOUT:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.sid_bad) status_next = ST_SCANOUT;
                    else if (!a_info_reg.rid_zero && rect_fail) status_next = ST_PARAM;
                CK_FLUSH:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.strict && a_info_reg.rid_zero)
                        status_next = ST_RESOURCE;
                    else if (rect_fail) status_next = ST_PARAM;
                CK_XFER_2D:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.rid_zero) status_next = ST_RESOURCE;
                    else if (rect_fail) status_next = ST_PARAM;
                CK_ATTACH:
                    if (!a_info_reg.len_gt32) status_next = ST_PARAM;
                    else if (a_info_reg.rid_zero) status_next = ST_RESOURCE;
                    else if (!a_info_reg.len_match) status_next = ST_PARAM;
                CK_CTX_CREATE:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.ctx_zero) status_next = ST_CONTEXT;
                    else if (a_info_reg.aux_big) status_next = ST_PARAM;
                CK_CTX_DESTROY:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.ctx_zero) status_next = ST_CONTEXT;
                CK_CTX_RES:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.ctx_zero) status_next = ST_CONTEXT;
                    else if (a_info_reg.strict && a_info_reg.rid_zero)
                        status_next = ST_RESOURCE;
                CK_CREATE_3D:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.rid_zero) status_next = ST_RESOURCE;
                    else if (size_fail) status_next = ST_PARAM;
                CK_XFER_3D:
                    if (!a_info_reg.len_match) status_next = ST_PARAM;
                    else if (a_info_reg.ctx_zero) status_next = ST_CONTEXT;
                    else if (a_info_reg.rid_zero) status_next = ST_RESOURCE;
                    else if (a_info_reg.zd_bad || rect_fail) status_next = ST_PARAM;
                CK_SUBMIT:
                    if (!a_info_reg.len_gt32) status_next = ST_PARAM;
                    else if (a_info_reg.ctx_zero) status_next = ST_CONTEXT;
                    else if (!a_info_reg.len_match) status_next = ST_PARAM;
                default:
                    status_next = ST_UNSPEC;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= a_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // width*height product, registered before the status decision
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            a_info_reg <= head_info;
            a_area_reg <= {31'd0, head_info.width} * {31'd0, head_info.height};
        end
        if (out_adv && a_valid_reg)
        begin
            out_status_reg <= status_next;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;

endmodule
`default_nettype wire

### hdl/gpu_command_validator.sv
`default_nettype none
// Control-queue command validator. Each beat on cmd is one parsed command; each beat on
// rsp is its status, in order. The block takes one command per clock when rsp is not
// stalled; a command passes through classification into a four-entry queue, the
// registered width*height multiply and the status register. The queue lets commands
// keep arriving for up to six beats while rsp is held. cfg is always ready; write it
// only while no command is in flight.
module gpu_command_validator (
    input  wire logic     clk,
    input  wire logic     rst_n,
    gcv_cmd_if.sink       cmd,
    gcv_cfg_if.sink       cfg,
    gcv_status_if.source  rsp
);
    import gcv_pkg::*;

    logic        strict_reg;
    logic        strict_next;
    logic [15:0] max_bytes_reg;
    logic [15:0] max_bytes_next;
    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    cmd_info_t   push_info;
    cmd_info_t   head_info;

    assign cfg.ready = 1'b1;

    assign strict_next    = (cfg.valid && cfg.index == CFG_STRICT) ? cfg.data[0] : strict_reg;
    assign max_bytes_next = (cfg.valid && cfg.index == CFG_MAX_BYTES) ? cfg.data
                                                                      : max_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_reg    <= 1'b0;
            max_bytes_reg <= MAX_BYTES_RST;
        end
        else
        begin
            strict_reg    <= strict_next;
            max_bytes_reg <= max_bytes_next;
        end
    end

    gcv_front u_front (
        .cmd        (cmd),
        .strict     (strict_reg),
        .max_bytes  (max_bytes_reg),
        .queue_full (queue_full),
        .push       (push),
        .info       (push_info)
    );

    gcv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_info (push_info),
        .full      (queue_full),
        .pop       (pop),
        .pop_info  (head_info),
        .empty     (queue_empty)
    );

    gcv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head_info   (head_info),
        .pop         (pop),
        .rsp         (rsp)
    );

endmodule
`default_nettype wire

### hdl/gcv_checker.sv
`default_nettype none
module gcv_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [2:0] rsp_status,
    input wire logic       cfg_valid,
    input wire logic       cfg_ready
);
    import gcv_pkg::*;

    localparam int CAPACITY = QUEUE_DEPTH + 2;

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = cmd_valid && cmd_ready;
    assign out_beat = rsp_valid && rsp_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (!in_beat && out_beat)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
        else $error("rsp beat changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("status without a pending command");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(CAPACITY))
        else $error("more commands in flight than storage");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_status <= ST_PARAM)
        else $error("status code out of range");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind gpu_command_validator gcv_checker u_gcv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .cfg_valid  (cfg.valid),
    .cfg_ready  (cfg.ready)
);
`default_nettype wire
